[rtl/utf8_to_code_point_decoder_macros.svh]
// ----------------------------------------------------------------------------
// utf8 decoder assertion macros
// concurrent assertion shorthands on i_clk with the active-low reset
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CODE_POINT_DECODER_MACROS_SVH
`define UTF8_TO_CODE_POINT_DECODER_MACROS_SVH

// property holds at every clock edge out of reset
`define UTF8D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
    `UTF8D_ASSERT(label, (ante) |=> (cons), msg)

`endif

[rtl/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8 decoder package
// constants and shared types of the utf8 to code point decoder
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

    localparam int unsigned CP_W = 21;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;

    typedef struct packed {
        logic            active;
        logic [1:0]      need;
        logic [1:0]      held;
        logic [CP_W-1:0] value;
    } t_seq_state;

    // replacement results first, then an optional tail result
    typedef struct packed {
        logic [1:0]      sub_cnt;
        logic            has_tail;
        logic [CP_W-1:0] tail_cp;
        logic            tail_subst;
        logic            text_end;
    } t_job;

endpackage

`default_nettype wire

[rtl/utf8_to_code_point_decoder.sv]
// ----------------------------------------------------------------------------
// utf8 to code point decoder
// path: a byte waits in the input register, then its results in the result job register
// throughput: one byte per cycle while each byte gives at most one result and the
//   receiver is ready; a byte with several results holds the single result register until all are taken
// reset: synchronous active low, clears the pipeline and any pending sequence
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_code_point_decoder_macros.svh"

module utf8_to_code_point_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // in_byte[7:0]
    input  wire logic        i_s_tlast,   // text_end
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // code_point[20:0], zero fill[23:21]
    output logic [1:0]       o_m_tuser,   // substituted[0], run_last[1]
    output logic             o_m_tlast    // text_done
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    utf8d_pkg::t_seq_state r_state;
    utf8d_pkg::t_seq_state n_state;
    logic                  r_job_valid;
    utf8d_pkg::t_job       r_job;
    utf8d_pkg::t_job       n_job;

    logic                       w_any;
    logic                       w_sel_sub;
    logic                       w_final;
    logic [utf8d_pkg::CP_W-1:0] w_cp;
    logic                       w_subst;
    logic                       w_out_hs;
    logic                       w_job_free;
    logic                       w_consume;
    logic                       w_in_hs;

    utf8d_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_state (n_state),
        .o_job   (n_job),
        .o_any   (w_any)
    );

    assign w_sel_sub = r_job.sub_cnt != 2'd0;
    assign w_final   = w_sel_sub ? ((r_job.sub_cnt == 2'd1) && !r_job.has_tail) : 1'b1;
    assign w_cp      = w_sel_sub ? utf8d_pkg::REPLACEMENT_CP : r_job.tail_cp;
    assign w_subst   = w_sel_sub ? 1'b1 : r_job.tail_subst;

    assign w_out_hs   = r_job_valid && i_m_tready;
    assign w_job_free = !r_job_valid || (w_out_hs && w_final);
    assign w_consume  = r_in_valid && w_job_free;
    assign o_s_tready = !r_in_valid || w_consume;
    assign w_in_hs    = i_s_tvalid && o_s_tready;

    assign o_m_tvalid = r_job_valid;
    assign o_m_tdata  = {3'b000, w_cp};
    assign o_m_tuser  = {w_final, w_subst};
    assign o_m_tlast  = w_final && r_job.text_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_job_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (w_in_hs) begin
                r_in_valid <= 1'b1;
            end else if (w_consume) begin
                r_in_valid <= 1'b0;
            end
            if (w_consume) begin
                r_state <= n_state;
            end
            if (w_consume && w_any) begin
                r_job_valid <= 1'b1;
            end else if (w_out_hs && w_final) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_hs) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (w_consume && w_any) begin
            r_job <= n_job;
        end else if (w_out_hs && !w_final && w_sel_sub) begin
            r_job.sub_cnt <= r_job.sub_cnt - 2'd1;
        end
    end

    `UTF8D_ASSERT(a_held_below_need, r_state.active |-> (r_state.held < r_state.need), "held count reached need")
    `UTF8D_ASSERT(a_idle_counts_zero, !r_state.active |-> ((r_state.held == 2'd0) && (r_state.need == 2'd0)), "counts left without sequence")
    `UTF8D_ASSERT_NEXT(a_end_clears_seq, w_consume && r_in_last, !r_state.active, "sequence kept past text end")
    `UTF8D_ASSERT(a_plain_is_final, (o_m_tvalid && !o_m_tuser[0]) |-> o_m_tuser[1], "decoded item not last of its byte")

endmodule

`default_nettype wire

[rtl/utf8d_decode.sv]
// ----------------------------------------------------------------------------
// utf8 byte decode
// next sequence state and the result job caused by one input byte
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_decode (
    input  wire utf8d_pkg::t_seq_state i_state,
    input  wire logic [7:0]            i_byte,
    input  wire logic                  i_last,
    output utf8d_pkg::t_seq_state      o_state,
    output utf8d_pkg::t_job            o_job,
    output logic                       o_any
);

    logic                       w_cont;
    logic [1:0]                 w_held_inc;
    logic [utf8d_pkg::CP_W-1:0] w_shifted;

    logic                       f_tail;
    logic [utf8d_pkg::CP_W-1:0] f_cp;
    logic                       f_subst;
    logic                       f_start;
    logic [1:0]                 f_need;
    logic [utf8d_pkg::CP_W-1:0] f_bits;

    assign w_cont     = (i_byte & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_TAG;
    assign w_held_inc = i_state.held + 2'd1;
    assign w_shifted  = {i_state.value[utf8d_pkg::CP_W-7:0], i_byte[5:0]};

    // byte decoded with no sequence pending
    always_comb begin
        f_tail  = 1'b1;
        f_cp    = utf8d_pkg::REPLACEMENT_CP;
        f_subst = 1'b1;
        f_start = 1'b0;
        f_need  = 2'd0;
        f_bits  = '0;
        priority if (!i_byte[7]) begin
            f_cp    = {{(utf8d_pkg::CP_W-8){1'b0}}, i_byte};
            f_subst = 1'b0;
        end else if ((i_byte & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_TAG) begin
            f_start = 1'b1;
            f_need  = 2'd1;
            f_bits  = {{(utf8d_pkg::CP_W-5){1'b0}}, i_byte[4:0]};
        end else if ((i_byte & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_TAG) begin
            f_start = 1'b1;
            f_need  = 2'd2;
            f_bits  = {{(utf8d_pkg::CP_W-4){1'b0}}, i_byte[3:0]};
        end else if ((i_byte & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_TAG) begin
            f_start = 1'b1;
            f_need  = 2'd3;
            f_bits  = {{(utf8d_pkg::CP_W-3){1'b0}}, i_byte[2:0]};
        end else begin
            f_tail = 1'b1;
        end
        // lead on the last byte of the text
        if (f_start) begin
            f_tail = i_last;
        end
        if (i_last) begin
            f_start = 1'b0;
        end
    end

    always_comb begin
        o_state          = i_state;
        o_job            = '0;
        o_job.text_end   = i_last;
        if (i_state.active && w_cont) begin
            o_state.value = w_shifted;
            o_state.held  = w_held_inc;
            if (w_held_inc == i_state.need) begin
                o_job.has_tail = 1'b1;
                o_job.tail_cp  = w_shifted;
                o_state        = '0;
            end else if (i_last) begin
                o_job.sub_cnt = w_held_inc + 2'd1;
                o_state       = '0;
            end
        end else begin
            if (i_state.active) begin
                o_job.sub_cnt = i_state.held + 2'd1;
            end
            o_job.has_tail   = f_tail;
            o_job.tail_cp    = f_cp;
            o_job.tail_subst = f_subst;
            o_state          = '0;
            if (f_start) begin
                o_state.active = 1'b1;
                o_state.need   = f_need;
                o_state.value  = f_bits;
            end
        end
        if (i_last) begin
            o_state = '0;
        end
    end

    assign o_any = (o_job.sub_cnt != 2'd0) || o_job.has_tail;

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// utf8 to code point decoder testbench
// drives a utf8 byte stream through the decoder with random idling on both
// sides and one long receiver hold-off; every accepted byte is decoded by a
// local predictor and each code point item is checked in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 150;
    localparam int RANDOM_ITEMS = 260;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } t_text_byte;

    typedef struct packed {
        logic [utf8d_pkg::CP_W-1:0] cp;
        logic                       subst;
        logic                       run_last;
        logic                       text_done;
    } t_cp_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [7:0]  i_s_tdata  = 8'h00;
    logic        i_s_tlast  = 1'b0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;   // code_point[20:0], zero fill[23:21]
    logic [1:0]  o_m_tuser;   // substituted[0], run_last[1]
    logic        o_m_tlast;   // text_done

    t_text_byte            pending_q[$];
    t_cp_result            cp_expected[$];
    t_cp_result            step_q[$];
    utf8d_pkg::t_seq_state seq = '0;

    int  err_count    = 0;
    int  in_count     = 0;
    int  cycle        = 0;
    int  holdoff_left = 0;
    bit  hold_done    = 1'b0;
    wire calm         = (in_count >= 150) && (in_count < 210);

    utf8_to_code_point_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    task add_result(input logic [utf8d_pkg::CP_W-1:0] cp, input logic subst);
        t_cp_result r;
        r.cp        = cp;
        r.subst     = subst;
        r.run_last  = 1'b0;
        r.text_done = 1'b0;
        step_q.push_back(r);
    endtask

    // lead and every held continuation each become a replacement
    task flush_pending();
        add_result(utf8d_pkg::REPLACEMENT_CP, 1'b1);
        for (int k = 0; k < int'(seq.held); k++)
            add_result(utf8d_pkg::REPLACEMENT_CP, 1'b1);
        seq = '0;
    endtask

    task decode_fresh(input logic [7:0] b, input logic last);
        logic [1:0]                 need;
        logic [utf8d_pkg::CP_W-1:0] bits;
        need = 2'd0;
        bits = '0;
        if (b[7] == 1'b0) begin
            add_result({13'd0, b}, 1'b0);
        end else begin
            if ((b & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_TAG) begin
                need = 2'd1;
                bits = {16'd0, b[4:0]};
            end else if ((b & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_TAG) begin
                need = 2'd2;
                bits = {17'd0, b[3:0]};
            end else if ((b & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_TAG) begin
                need = 2'd3;
                bits = {18'd0, b[2:0]};
            end
            if (need == 2'd0 || last) begin
                add_result(utf8d_pkg::REPLACEMENT_CP, 1'b1);
            end else begin
                seq.active = 1'b1;
                seq.need   = need;
                seq.held   = 2'd0;
                seq.value  = bits;
            end
        end
    endtask

    task predict_byte(input logic [7:0] b, input logic last);
        t_cp_result r;
        step_q.delete();
        if (seq.active) begin
            if ((b & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_TAG) begin
                seq.value = {seq.value[utf8d_pkg::CP_W-7:0], b[5:0]};
                seq.held  = seq.held + 2'd1;
                if (seq.held == seq.need) begin
                    add_result(seq.value, 1'b0);
                    seq = '0;
                end else if (last) begin
                    flush_pending();
                end
            end else begin
                flush_pending();
                decode_fresh(b, last);
            end
        end else begin
            decode_fresh(b, last);
        end
        if (step_q.size() > 0) begin
            r = step_q[step_q.size()-1];
            r.run_last  = 1'b1;
            r.text_done = last;
            step_q[step_q.size()-1] = r;
        end
        if (last)
            seq = '0;
        foreach (step_q[i])
            cp_expected.push_back(step_q[i]);
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        t_text_byte nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
                nxt = pending_q.pop_front();
                i_s_tdata  <= nxt.b;
                i_s_tlast  <= nxt.last;
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- receiver hold-off ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holdoff_left <= 0;
        end else if (in_count == HOLD_AT && !hold_done) begin
            holdoff_left <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_cp_result got;
        t_cp_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_byte(i_s_tdata, i_s_tlast);
                in_count <= in_count + 1;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.cp        = o_m_tdata[utf8d_pkg::CP_W-1:0];
                got.subst     = o_m_tuser[0];
                got.run_last  = o_m_tuser[1];
                got.text_done = o_m_tlast;
                if (cp_expected.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected item: cp %h subst %b run_last %b done %b",
                                 got.cp, got.subst, got.run_last, got.text_done);
                end else begin
                    want = cp_expected.pop_front();
                    if (got != want || o_m_tdata[23:utf8d_pkg::CP_W] != '0) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("mismatch: expected cp %h subst %b run_last %b done %b, got tdata %h subst %b run_last %b done %b",
                                     want.cp, want.subst, want.run_last, want.text_done,
                                     o_m_tdata, got.subst, got.run_last, got.text_done);
                    end
                end
            end
            i_m_tready <= (holdoff_left == 0) && (calm || $urandom_range(99) >= 27);
        end
    end

    // ---------------- timeout ----------------
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle == LIMIT_CYCLES) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task add_byte(input logic [7:0] b, input logic last);
        t_text_byte t;
        t.b    = b;
        t.last = last;
        pending_q.push_back(t);
    endtask

    function automatic logic [7:0] lead_of(input int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            2: r = {3'b110, r[4:0]};
            3: r = {4'b1110, r[3:0]};
            default: r = {5'b11110, r[2:0]};
        endcase
        return r;
    endfunction

    function automatic logic [7:0] cont_byte();
        logic [7:0] r;
        r = 8'($urandom);
        return {2'b10, r[5:0]};
    endfunction

    function automatic logic rand_end();
        return $urandom_range(11) == 0;
    endfunction

    initial begin
        int         kind;
        int         len;
        int         ncont;
        logic [7:0] b;

        // directed: ascii extremes, one of each length, top code point
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b1);
        add_byte(8'hC3, 1'b0); add_byte(8'hA9, 1'b0);
        add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hAC, 1'b0);
        add_byte(8'hF7, 1'b0); add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
        // stray continuation and the invalid bytes ff and f8
        add_byte(8'h80, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hF8, 1'b0);
        // sequence broken by a new lead, then text ends mid sequence
        add_byte(8'hE2, 1'b0); add_byte(8'h82, 1'b0);
        add_byte(8'hF0, 1'b0); add_byte(8'h90, 1'b0); add_byte(8'h80, 1'b1);
        // lead carrying text end
        add_byte(8'hC2, 1'b1);
        // broken by ascii, broken by an invalid byte, invalid byte ending text
        add_byte(8'hC2, 1'b0); add_byte(8'h41, 1'b0);
        add_byte(8'hE0, 1'b0); add_byte(8'hF9, 1'b0);
        add_byte(8'hFE, 1'b1);

        // random: mostly well-formed sequences, some broken ones and noise
        while (pending_q.size() < RANDOM_ITEMS) begin
            kind = $urandom_range(99);
            if (kind < 25) begin
                b = 8'($urandom);
                add_byte({1'b0, b[6:0]}, rand_end());
            end else if (kind < 75) begin
                len = $urandom_range(4, 2);
                add_byte(lead_of(len), rand_end());
                for (int k = 1; k < len; k++)
                    add_byte(cont_byte(), rand_end());
            end else if (kind < 88) begin
                len   = $urandom_range(4, 2);
                ncont = $urandom_range(len - 2, 0);
                add_byte(lead_of(len), 1'b0);
                for (int k = 0; k < ncont; k++)
                    add_byte(cont_byte(), 1'b0);
                b = 8'($urandom);
                while ((b & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_TAG)
                    b = 8'($urandom);
                add_byte(b, rand_end());
            end else begin
                add_byte(8'($urandom), rand_end());
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (cp_expected.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
